// File: hdl/thp_pkg.sv
// thp_pkg: shared types and constants for the timer heap scheduler
// no dependencies
`timescale 1ns / 1ps

package thp_pkg;

	localparam int SlotsDef = 16;
	localparam int MaxOut   = 16;
	localparam int TimeW    = 48;
	localparam int OrderW   = 32;

	localparam logic [1:0] OpTick   = 2'd0;
	localparam logic [1:0] OpAdd    = 2'd1;
	localparam logic [1:0] OpStop   = 2'd2;
	localparam logic [1:0] OpUnused = 2'd3;

	localparam logic [1:0] KindAdd    = 2'd0;
	localparam logic [1:0] KindStop   = 2'd1;
	localparam logic [1:0] KindExpiry = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic        advance;
		logic [31:0] duration;
		logic        looped;
		logic [3:0]  slot;
		logic [31:0] serial;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  timer_slot;
		logic [31:0] timer_serial;
		logic        ok;
		logic        last;
	} res_t;

endpackage

// File: hdl/timer_heap_scheduler.sv
// timer_heap_scheduler: top level, slot table, binary min-heap and sequencer
// depends on thp_pkg and thp_cmp
`timescale 1ns / 1ps

// A command word is taken when start is high and busy is low. A tick, an add
// with a free slot or a stop of a live timer raises busy until the final
// result word of that command is launched, and that word shows up in the
// first cycle with busy low; a full add or a rejected stop leaves busy low
// and answers in the next cycle. Results come one per cycle at most, each
// held for exactly one cycle with result_valid high; the receiver cannot
// stall them, so it must take every marked word. Add and stop give one word
// each; a tick gives one word per expired timer (at most 16) or none, and the
// final word of a command carries last. Timing is set by the single shared
// heap compare: sifting up climbs one heap level per cycle, sifting down takes
// ST_SD_A then ST_SD_B per level. An add sifts up, a stop sifts up or down,
// a tick pulls each expiry, re-adds it if looped and closes with a check.

module timer_heap_scheduler #(
	parameter int SLOTS = thp_pkg::SlotsDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  thp_pkg::cmd_t   cmd,
	output logic            busy,
	output logic            result_valid,
	output thp_pkg::res_t   result
);

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = SW + 2;
	localparam int XW = SW + 5;
	localparam int TW = thp_pkg::TimeW;
	localparam int OW = thp_pkg::OrderW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TK_CHECK, ST_TK_REARM, ST_RM, ST_RM_FIX,
		ST_SU, ST_SD_A, ST_SD_B, ST_ADD_FIN, ST_STOP_FIN
	} state_t;

	state_t state_q, ret_q;

	// slot table
	logic [TW-1:0] exp_q  [SLOTS];
	logic [31:0]   per_q  [SLOTS];
	logic [31:0]   ser_q  [SLOTS];
	logic [OW-1:0] ord_q  [SLOTS];
	logic          act_q  [SLOTS];
	logic          rep_q  [SLOTS];
	logic [SW:0]   link_q [SLOTS];
	// heap
	logic [SW-1:0] heap_q [SLOTS];
	logic [SW-1:0] pos_q  [SLOTS];

	logic [SW:0]   cnt_q, free_q, used_q;
	logic [31:0]   nser_q;
	logic [OW-1:0] nord_q;
	logic [TW-1:0] now_q, target_q;
	logic [SW-1:0] i_q, best_q, s_q;
	logic [4:0]    n_q;
	thp_pkg::res_t pend_q;
	logic          pend_v_q;
	logic          rv_q;
	thp_pkg::res_t res_q;

	// index arithmetic around the current heap node
	logic [SW-1:0] par;
	logic [CW-1:0] l_w, r_w, cnt_w;
	logic [SW-1:0] ca, cb;
	logic          a_first;
	logic [SW-1:0] top_s, add_s;
	logic [XW-1:0] stop_x;
	logic [SW-1:0] stop_s;
	logic [31:0]   nser_inc;
	logic [SW:0]   last_idx;

	assign par      = SW'((i_q - 1'b1) >> 1);
	assign l_w      = CW'({i_q, 1'b1});
	assign r_w      = l_w + 1'b1;
	assign cnt_w    = CW'(cnt_q);
	assign top_s    = heap_q[0];
	assign add_s    = (free_q < (SW+1)'(SLOTS)) ? free_q[SW-1:0] : used_q[SW-1:0];
	assign stop_x   = XW'(cmd.slot);
	assign stop_s   = stop_x[SW-1:0];
	assign nser_inc = nser_q + 32'd1;
	assign last_idx = cnt_q - 1'b1;

	// operand select for the shared compare
	always_comb begin
		case (state_q)
			ST_SD_A: begin
				ca = heap_q[r_w[SW-1:0]];
				cb = heap_q[l_w[SW-1:0]];
			end
			ST_SD_B: begin
				ca = heap_q[best_q];
				cb = heap_q[i_q];
			end
			default: begin
				ca = heap_q[i_q];
				cb = heap_q[par];
			end
		endcase
	end

	thp_cmp u_cmp (
		.exp_a   (exp_q[ca]),
		.ord_a   (ord_q[ca]),
		.exp_b   (exp_q[cb]),
		.ord_b   (ord_q[cb]),
		.a_first (a_first)
	);

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = rv_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			cnt_q    <= '0;
			free_q   <= (SW+1)'(SLOTS);
			used_q   <= '0;
			nser_q   <= 32'd1;
			nord_q   <= '0;
			now_q    <= '0;
			pend_v_q <= 1'b0;
			rv_q     <= 1'b0;
			n_q      <= '0;
			for (int k = 0; k < SLOTS; k++) begin
				act_q[k] <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd.operation)
							thp_pkg::OpTick: begin
								rv_q     <= 1'b0;
								target_q <= now_q + TW'(cmd.advance);
								now_q    <= now_q + TW'(cmd.advance);
								n_q      <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_TK_CHECK;
							end
							thp_pkg::OpAdd: begin
								if (free_q < (SW+1)'(SLOTS) || used_q < (SW+1)'(SLOTS)) begin
									rv_q <= 1'b0;
									if (free_q < (SW+1)'(SLOTS))
										free_q <= link_q[free_q[SW-1:0]];
									else
										used_q <= used_q + 1'b1;
									per_q[add_s] <= cmd.duration;
									exp_q[add_s] <= now_q + TW'(cmd.duration);
									ser_q[add_s] <= nser_q;
									nser_q       <= (nser_inc == 32'd0) ? 32'd1 : nser_inc;
									ord_q[add_s] <= nord_q;
									nord_q       <= nord_q + 1'b1;
									act_q[add_s] <= 1'b1;
									rep_q[add_s] <= cmd.looped;
									s_q          <= add_s;
									// push at the heap tail, then sift up
									heap_q[cnt_q[SW-1:0]] <= add_s;
									pos_q[add_s]          <= cnt_q[SW-1:0];
									cnt_q                 <= cnt_q + 1'b1;
									i_q                   <= cnt_q[SW-1:0];
									ret_q                 <= ST_ADD_FIN;
									state_q               <= ST_SU;
								end else begin
									rv_q  <= 1'b1;
									res_q <= '{kind: thp_pkg::KindAdd, timer_slot: '0,
										timer_serial: '0, ok: 1'b0, last: 1'b1};
								end
							end
							thp_pkg::OpStop: begin
								if (stop_x < XW'(SLOTS) && act_q[stop_s] &&
								    ser_q[stop_s] == cmd.serial) begin
									rv_q           <= 1'b0;
									act_q[stop_s]  <= 1'b0;
									link_q[stop_s] <= free_q;
									free_q         <= (SW+1)'(stop_s);
									i_q            <= pos_q[stop_s];
									ret_q          <= ST_STOP_FIN;
									state_q        <= ST_RM;
								end else begin
									rv_q  <= 1'b1;
									res_q <= '{kind: thp_pkg::KindStop, timer_slot: '0,
										timer_serial: '0, ok: 1'b0, last: 1'b1};
								end
							end
							default: rv_q <= 1'b0;
						endcase
					end else begin
						rv_q <= 1'b0;
					end
				end
				ST_TK_CHECK: begin
					rv_q <= pend_v_q;
					if (cnt_q == '0 || n_q == 5'(thp_pkg::MaxOut) ||
					    exp_q[top_s] > target_q) begin
						if (pend_v_q) begin
							res_q <= '{kind: pend_q.kind, timer_slot: pend_q.timer_slot,
								timer_serial: pend_q.timer_serial, ok: pend_q.ok,
								last: 1'b1};
						end
						state_q <= ST_IDLE;
					end else begin
						// previous expiry is not the last one, send it now
						if (pend_v_q) begin
							res_q <= pend_q;
						end
						pend_q   <= '{kind: thp_pkg::KindExpiry, timer_slot: 4'(top_s),
							timer_serial: ser_q[top_s], ok: 1'b1, last: 1'b0};
						pend_v_q <= 1'b1;
						n_q      <= n_q + 1'b1;
						s_q      <= top_s;
						i_q      <= '0;
						ret_q    <= ST_TK_REARM;
						state_q  <= ST_RM;
					end
				end
				ST_TK_REARM: begin
					rv_q <= 1'b0;
					if (rep_q[s_q]) begin
						exp_q[s_q] <= exp_q[s_q] +
							((per_q[s_q] == 32'd0) ? TW'(1) : TW'(per_q[s_q]));
						ord_q[s_q] <= nord_q;
						nord_q     <= nord_q + 1'b1;
						heap_q[cnt_q[SW-1:0]] <= s_q;
						pos_q[s_q]            <= cnt_q[SW-1:0];
						cnt_q                 <= cnt_q + 1'b1;
						i_q                   <= cnt_q[SW-1:0];
						ret_q                 <= ST_TK_CHECK;
						state_q               <= ST_SU;
					end else begin
						act_q[s_q]  <= 1'b0;
						link_q[s_q] <= free_q;
						free_q      <= (SW+1)'(s_q);
						state_q     <= ST_TK_CHECK;
					end
				end
				ST_RM: begin
					rv_q <= 1'b0;
					// move the tail entry into the hole
					cnt_q <= last_idx;
					if ((SW+1)'(i_q) == last_idx) begin
						state_q <= ret_q;
					end else begin
						heap_q[i_q]                     <= heap_q[last_idx[SW-1:0]];
						pos_q[heap_q[last_idx[SW-1:0]]] <= i_q;
						state_q                         <= ST_RM_FIX;
					end
				end
				ST_RM_FIX: begin
					rv_q <= 1'b0;
					if (i_q != '0 && a_first) begin
						heap_q[i_q]         <= heap_q[par];
						heap_q[par]         <= heap_q[i_q];
						pos_q[heap_q[i_q]]  <= par;
						pos_q[heap_q[par]]  <= i_q;
						i_q                 <= par;
						state_q             <= ST_SU;
					end else begin
						state_q <= ST_SD_A;
					end
				end
				ST_SU: begin
					rv_q <= 1'b0;
					if (i_q != '0 && a_first) begin
						heap_q[i_q]         <= heap_q[par];
						heap_q[par]         <= heap_q[i_q];
						pos_q[heap_q[i_q]]  <= par;
						pos_q[heap_q[par]]  <= i_q;
						i_q                 <= par;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_SD_A: begin
					rv_q <= 1'b0;
					if (l_w >= cnt_w) begin
						state_q <= ret_q;
					end else begin
						best_q  <= (r_w < cnt_w && a_first) ? r_w[SW-1:0] : l_w[SW-1:0];
						state_q <= ST_SD_B;
					end
				end
				ST_SD_B: begin
					rv_q <= 1'b0;
					if (a_first) begin
						heap_q[i_q]           <= heap_q[best_q];
						heap_q[best_q]        <= heap_q[i_q];
						pos_q[heap_q[i_q]]    <= best_q;
						pos_q[heap_q[best_q]] <= i_q;
						i_q                   <= best_q;
						state_q               <= ST_SD_A;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_ADD_FIN: begin
					rv_q    <= 1'b1;
					res_q   <= '{kind: thp_pkg::KindAdd, timer_slot: 4'(s_q),
						timer_serial: ser_q[s_q], ok: 1'b1, last: 1'b1};
					state_q <= ST_IDLE;
				end
				ST_STOP_FIN: begin
					rv_q    <= 1'b1;
					res_q   <= '{kind: thp_pkg::KindStop, timer_slot: '0,
						timer_serial: '0, ok: 1'b1, last: 1'b1};
					state_q <= ST_IDLE;
				end
				default: begin
					rv_q    <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the final word of a command always leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("last word while busy");

	// expiry words always report ok
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == thp_pkg::KindExpiry |-> result.ok)
		else $error("expiry without ok");

	// the heap never holds more timers than slots
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (SW+1)'(SLOTS))
		else $error("heap overflow");

	// a tick always starts a heap scan
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.operation == thp_pkg::OpTick |=> busy)
		else $error("tick not taken");

endmodule

// File: hdl/thp_cmp.sv
// thp_cmp: shared heap order compare, expiry time first, then order key
// depends on thp_pkg
`timescale 1ns / 1ps

module thp_cmp (
	input  logic [thp_pkg::TimeW-1:0]  exp_a,
	input  logic [thp_pkg::OrderW-1:0] ord_a,
	input  logic [thp_pkg::TimeW-1:0]  exp_b,
	input  logic [thp_pkg::OrderW-1:0] ord_b,
	output logic                       a_first
);

	assign a_first = {exp_a, ord_a} < {exp_b, ord_b};

endmodule

// File: sim/timer_heap_scheduler_test.sv
// timer_heap_scheduler_test: self-checking bench for the timer heap scheduler
// holds its own heap and slot table model and compares each result word; needs thp_pkg
`timescale 1ns / 1ps

module timer_heap_scheduler_test;

	localparam int NSLOT = thp_pkg::SlotsDef;
	localparam int QUIET_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	thp_pkg::cmd_t cmd;
	logic busy;
	logic result_valid;
	thp_pkg::res_t result;

	timer_heap_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow of the scheduler state
	logic [47:0] clock_now;
	logic [47:0] due_at [NSLOT];
	logic [31:0] reload [NSLOT];
	logic [31:0] handle_serial [NSLOT];
	logic [31:0] tie_key [NSLOT];
	bit          live [NSLOT];
	bit          rearm [NSLOT];
	int          heap_at [NSLOT];
	int          heap_node [NSLOT];
	int          free_next [NSLOT];
	int          heap_len;
	int          free_top;
	int          fresh_used;
	logic [31:0] serial_next;
	logic [31:0] key_next;

	thp_pkg::res_t expected_words [$];
	int   errors;
	int   quiet_cycles;
	bit   burst_mode;

	function automatic bit fires_first(int a, int b);
		if (due_at[a] != due_at[b])
			return due_at[a] < due_at[b];
		return tie_key[a] < tie_key[b];
	endfunction

	function automatic void swap_nodes(int i, int j);
		int t;
		t = heap_node[i];
		heap_node[i] = heap_node[j];
		heap_node[j] = t;
		heap_at[heap_node[i]] = i;
		heap_at[heap_node[j]] = j;
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!fires_first(heap_node[i], heap_node[p]))
				break;
			swap_nodes(i, p);
			i = p;
		end
	endfunction

	function automatic void bubble_down(int i);
		int l;
		int best;
		forever begin
			l = 2 * i + 1;
			if (l >= heap_len)
				break;
			best = l;
			if (l + 1 < heap_len && fires_first(heap_node[l + 1], heap_node[l]))
				best = l + 1;
			if (!fires_first(heap_node[best], heap_node[i]))
				break;
			swap_nodes(i, best);
			i = best;
		end
	endfunction

	function automatic void heap_insert(int s);
		heap_node[heap_len] = s;
		heap_at[s] = heap_len;
		heap_len++;
		bubble_up(heap_len - 1);
	endfunction

	function automatic void heap_take(int i);
		int tail;
		if (heap_len == 0 || i >= heap_len)
			return;
		tail = heap_len - 1;
		heap_len = tail;
		if (i == tail)
			return;
		heap_node[i] = heap_node[tail];
		heap_at[heap_node[i]] = i;
		if (i > 0 && fires_first(heap_node[i], heap_node[(i - 1) / 2]))
			bubble_up(i);
		else
			bubble_down(i);
	endfunction

	function automatic void free_slot(int s);
		live[s] = 1'b0;
		free_next[s] = free_top;
		free_top = s;
	endfunction

	function automatic void clear_shadow();
		clock_now = '0;
		heap_len = 0;
		free_top = NSLOT;
		fresh_used = 0;
		serial_next = 32'd1;
		key_next = '0;
		for (int k = 0; k < NSLOT; k++) begin
			live[k] = 1'b0;
			rearm[k] = 1'b0;
		end
	endfunction

	// works out the words that one accepted command will bring
	function automatic void predict_command(thp_pkg::cmd_t c);
		thp_pkg::res_t words [$];
		thp_pkg::res_t w;
		logic [47:0] target;
		int s;
		w = '0;
		case (c.operation)
			thp_pkg::OpTick: begin
				target = clock_now + 48'(c.advance);
				while (heap_len > 0 && words.size() < thp_pkg::MaxOut) begin
					s = heap_node[0];
					if (due_at[s] > target)
						break;
					heap_take(0);
					w.kind = thp_pkg::KindExpiry;
					w.timer_slot = 4'(s);
					w.timer_serial = handle_serial[s];
					w.ok = 1'b1;
					w.last = 1'b0;
					words = {words, w};
					if (rearm[s]) begin
						due_at[s] = due_at[s] + ((reload[s] != 0) ? 48'(reload[s]) : 48'd1);
						tie_key[s] = key_next;
						key_next++;
						heap_insert(s);
					end else begin
						free_slot(s);
					end
				end
				clock_now = target;
				foreach (words[k]) begin
					w = words[k];
					w.last = (k == words.size() - 1);
					expected_words = {expected_words, w};
				end
			end
			thp_pkg::OpAdd: begin
				s = -1;
				if (free_top < NSLOT) begin
					s = free_top;
					free_top = free_next[s];
				end else if (fresh_used < NSLOT) begin
					s = fresh_used;
					fresh_used++;
				end
				w.kind = thp_pkg::KindAdd;
				w.last = 1'b1;
				if (s >= 0) begin
					reload[s] = c.duration;
					due_at[s] = clock_now + 48'(c.duration);
					handle_serial[s] = serial_next;
					serial_next++;
					if (serial_next == 0)
						serial_next = 32'd1;
					tie_key[s] = key_next;
					key_next++;
					live[s] = 1'b1;
					rearm[s] = c.looped;
					heap_insert(s);
					w.timer_slot = 4'(s);
					w.timer_serial = handle_serial[s];
					w.ok = 1'b1;
				end
				expected_words = {expected_words, w};
			end
			thp_pkg::OpStop: begin
				s = int'(c.slot);
				w.kind = thp_pkg::KindStop;
				w.last = 1'b1;
				if (live[s] && handle_serial[s] == c.serial) begin
					heap_take(heap_at[s]);
					free_slot(s);
					w.ok = 1'b1;
				end
				expected_words = {expected_words, w};
			end
			default: ;
		endcase
	endfunction

	// predict on every accepted command word
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			predict_command(cmd);
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// each result word is checked against the oldest prediction
	always @(posedge clk) begin
		thp_pkg::res_t want;
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, result);
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("kind", 32'(want.kind), 32'(result.kind));
				check_field("timer_slot", 32'(want.timer_slot), 32'(result.timer_slot));
				check_field("timer_serial", want.timer_serial, result.timer_serial);
				check_field("ok", 32'(want.ok), 32'(result.ok));
				check_field("last", 32'(want.last), 32'(result.last));
			end
		end
	end

	// watchdog on cycles with no handshake of either kind
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// mostly short gaps, a few long ones, none in burst mode
	task automatic idle_gap();
		int r;
		int g;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 50)
			g = 0;
		else if (r < 90)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(10, 40);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drives one command word and holds it until the block takes it
	task automatic send_word(thp_pkg::cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do
			@(posedge clk);
		while (busy);
		idle_gap();
	endtask

	// unused fields get random bits so every bit toggles
	function automatic thp_pkg::cmd_t noise_word();
		thp_pkg::cmd_t c;
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		c = bits[$bits(thp_pkg::cmd_t)-1:0];
		return c;
	endfunction

	task automatic send_add(logic [31:0] dur, bit loop_it);
		thp_pkg::cmd_t c;
		c = noise_word();
		c.operation = thp_pkg::OpAdd;
		c.duration = dur;
		c.looped = loop_it;
		send_word(c);
	endtask

	task automatic send_tick(bit adv);
		thp_pkg::cmd_t c;
		c = noise_word();
		c.operation = thp_pkg::OpTick;
		c.advance = adv;
		send_word(c);
	endtask

	task automatic send_stop(int s, logic [31:0] ser);
		thp_pkg::cmd_t c;
		c = noise_word();
		c.operation = thp_pkg::OpStop;
		c.slot = 4'(s);
		c.serial = ser;
		send_word(c);
	endtask

	// single timers, extreme durations, handle checks, unknown operation
	task automatic test_basic_commands();
		thp_pkg::cmd_t c;
		send_add(32'd0, 1'b0);
		send_tick(1'b0);
		send_add(32'hffff_ffff, 1'b1);
		send_stop(0, 32'd99);
		send_stop(0, 32'd2);
		send_stop(0, 32'd2);
		send_stop(15, 32'hffff_ffff);
		c = noise_word();
		c.operation = thp_pkg::OpUnused;
		send_word(c);
		send_tick(1'b1);
	endtask

	// fill every slot with zero-period looped timers, overflow the table,
	// then a tick that owes 32 expiries is capped at 16 and the rest follow
	task automatic test_full_table_and_cap();
		for (int k = 0; k < NSLOT; k++)
			send_add(32'd0, 1'b1);
		send_add(32'd5, 1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// mixed traffic, stops mostly with live handles, durations mostly short
	task automatic test_random_mix(int count);
		int r;
		int s;
		logic [31:0] dur;
		thp_pkg::cmd_t c;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_tick($urandom_range(0, 3) != 0);
			end else if (r < 75) begin
				r = $urandom_range(0, 19);
				dur = (r == 0) ? $urandom : (r == 1) ? 32'hffff_ffff : $urandom_range(0, 8);
				send_add(dur, $urandom_range(0, 2) == 0);
			end else if (r < 96) begin
				s = $urandom_range(0, NSLOT - 1);
				if (live[s] && $urandom_range(0, 9) < 7)
					send_stop(s, handle_serial[s]);
				else
					send_stop(s, ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 40)));
			end else begin
				c = noise_word();
				c.operation = thp_pkg::OpUnused;
				send_word(c);
			end
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		errors = 0;
		quiet_cycles = 0;
		burst_mode = 1'b0;
		clear_shadow();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_full_table_and_cap();
		test_random_mix(400);

		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0 || busy)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
